// ===== src/rbp_pkg.sv =====
package rbp_pkg;

  // Field widths fixed by the block's interface
  localparam int unsigned CAP_W = 5;
  localparam int unsigned HDL_W = 4;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned SIG_W = 16;
  localparam int unsigned TOT_W = 32;

  // Reference count ceiling
  localparam logic [CNT_W-1:0] REF_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RETAIN  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_QUERY   = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [HDL_W-1:0]   block_index;
    logic [SIG_W-1:0]   signal;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [HDL_W-1:0]   result_index;
    logic [CNT_W-1:0]   ref_count;
    logic [SIG_W-1:0]   event_signal;
    logic [CAP_W-1:0]   blocks_in_use;
    logic [CAP_W-1:0]   peak_in_use;
    logic [TOT_W-1:0]   allocations;
    logic [TOT_W-1:0]   failures;
    logic [TOT_W-1:0]   releases;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic cfg_we;
  } ctrl_t;

endpackage

// ===== src/refcounted_block_pool_top.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------
// request  | in        | start high, busy low      | req_i (rbp_pkg::req_t)
// result   | out       | done_o for one cycle      | res_o (rbp_pkg::res_t)
// config   | in        | cfg_valid_i && cfg_ready_o | cfg_data_i (capacity)
//
// Each request runs in two steps: first it is latched, the used map is searched for the
// lowest free block and the addressed block is read; then the block is updated.
// done_o rises the cycle after the update; a new request is taken then too.
// Reset clears the pool and sets capacity to the smaller of 16 and POOL_BLOCKS.
// The receiver cannot stall; config is taken only while busy and start are low.
module refcounted_block_pool_top
  import rbp_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  ctrl_t ctl;

  rbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cfg_valid_i (cfg_valid_i),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o),
    .ctl_o       (ctl)
  );

  rbp_datapath #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .req_i      (req_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ===== src/rbp_ctrl.sv =====
module rbp_ctrl
  import rbp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  cfg_valid_i,
  output logic  busy,
  output logic  cfg_ready_o,
  output ctrl_t ctl_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands; a request beat takes the edge over a config beat
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
        ctl_o.cfg_we = cfg_valid_i && !start;
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy        = (state_q == ST_EXEC);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;

endmodule

// ===== src/rbp_datapath.sv =====
module rbp_datapath
  import rbp_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctl_i,
  input  req_t             req_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output logic             done_o,
  output res_t             res_o
);

  // Blocks reachable through a 5-bit capacity
  localparam int unsigned CAP_LIMIT = (1 << CAP_W) - 1;
  localparam int unsigned DEPTH     = (POOL_BLOCKS < CAP_LIMIT) ? POOL_BLOCKS : CAP_LIMIT;
  localparam int unsigned IDXW      = $clog2(DEPTH);
  localparam int unsigned CAP_RST   = (POOL_BLOCKS < 16) ? POOL_BLOCKS : 16;

  logic [CAP_W-1:0]  capacity_q;
  logic [DEPTH-1:0]  used_q, used_d;
  logic [CAP_W-1:0]  in_use_q, in_use_d;
  logic [CAP_W-1:0]  peak_q, peak_d;
  logic [TOT_W-1:0]  alloc_q, alloc_d;
  logic [TOT_W-1:0]  fail_q, fail_d;
  logic [TOT_W-1:0]  rel_q, rel_d;

  // Count and signal storage; a block's contents count only while it is used
  logic [CNT_W-1:0]  cnt_mem [DEPTH];
  logic [SIG_W-1:0]  sig_mem [DEPTH];

  req_t              cmd_q;
  logic              found_q;
  logic [IDXW-1:0]   free_idx_q;
  logic              hit_q;
  logic [IDXW-1:0]   addr_q;
  logic [CNT_W-1:0]  rd_cnt_q;
  logic [SIG_W-1:0]  rd_sig_q;

  logic              found;
  logic [IDXW-1:0]   free_idx;
  logic [IDXW+HDL_W-1:0] req_wide;
  logic [IDXW-1:0]   req_addr;
  logic              req_hit;
  logic              cfg_ok;

  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  logic [CNT_W-1:0]  wr_cnt;
  logic              wr_sig_en;
  logic [IDXW+HDL_W-1:0] free_wide;
  res_t              res_d;

  // Find the lowest free block below capacity
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!found && !used_q[i] && (32'(i) < 32'(capacity_q))) begin
        found    = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  // Decode the addressed block
  assign req_wide = {{IDXW{1'b0}}, req_i.block_index};
  assign req_addr = req_wide[IDXW-1:0];
  assign req_hit  = ({1'b0, req_i.block_index} < capacity_q) && used_q[req_addr];
  assign cfg_ok   = (cfg_data_i != '0) && (32'(cfg_data_i) <= POOL_BLOCKS);

  // Latch the request, the search and the addressed block
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q      <= req_i;
      found_q    <= found;
      free_idx_q <= free_idx;
      hit_q      <= req_hit;
      addr_q     <= req_addr;
      rd_cnt_q   <= cnt_mem[req_addr];
      rd_sig_q   <= sig_mem[req_addr];
    end
  end

  assign free_wide = {{HDL_W{1'b0}}, free_idx_q};

  // Apply the operation to the latched block
  always_comb begin
    used_d    = used_q;
    in_use_d  = in_use_q;
    peak_d    = peak_q;
    alloc_d   = alloc_q;
    fail_d    = fail_q;
    rel_d     = rel_q;
    wr_en     = 1'b0;
    wr_addr   = addr_q;
    wr_cnt    = rd_cnt_q;
    wr_sig_en = 1'b0;
    res_d     = '0;
    res_d.result_index = cmd_q.block_index;

    if (cmd_q.action == ACT_ALLOC) begin
      res_d.result_index = '0;
      if (found_q) begin
        wr_en     = 1'b1;
        wr_sig_en = 1'b1;
        wr_addr   = free_idx_q;
        wr_cnt    = CNT_W'(1);
        used_d[free_idx_q] = 1'b1;
        in_use_d  = CAP_W'(in_use_q + 1'b1);
        alloc_d   = alloc_q + 1'b1;
        res_d.ok           = 1'b1;
        res_d.result_index = free_wide[HDL_W-1:0];
        res_d.ref_count    = CNT_W'(1);
        res_d.event_signal = cmd_q.signal;
      end else begin
        fail_d = fail_q + 1'b1;
      end
    end else if (hit_q) begin
      res_d.ref_count    = rd_cnt_q;
      res_d.event_signal = rd_sig_q;
      priority case (cmd_q.action)
        ACT_RETAIN: begin
          if (rd_cnt_q != REF_MAX) begin
            wr_en           = 1'b1;
            wr_cnt          = rd_cnt_q + 1'b1;
            res_d.ok        = 1'b1;
            res_d.ref_count = wr_cnt;
          end
        end
        ACT_RELEASE: begin
          if (rd_cnt_q != '0) begin
            wr_en           = 1'b1;
            wr_cnt          = rd_cnt_q - 1'b1;
            res_d.ok        = 1'b1;
            res_d.ref_count = wr_cnt;
            // Free the block on its last reference
            if (wr_cnt == '0) begin
              used_d[addr_q]     = 1'b0;
              in_use_d           = CAP_W'(in_use_q - 1'b1);
              rel_d              = rel_q + 1'b1;
              res_d.event_signal = '0;
            end
          end
        end
        default: res_d.ok = 1'b1;
      endcase
    end

    if (in_use_d > peak_q) begin
      peak_d = in_use_d;
    end

    res_d.blocks_in_use = in_use_d;
    res_d.peak_in_use   = peak_d;
    res_d.allocations   = alloc_d;
    res_d.failures      = fail_d;
    res_d.releases      = rel_d;
  end

  // Write back the block
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && wr_en) begin
      cnt_mem[wr_addr] <= wr_cnt;
      if (wr_sig_en) begin
        sig_mem[wr_addr] <= cmd_q.signal;
      end
    end
  end

  // Pool state and statistics; a valid capacity write clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_W'(CAP_RST);
      used_q     <= '0;
      in_use_q   <= '0;
      peak_q     <= '0;
      alloc_q    <= '0;
      fail_q     <= '0;
      rel_q      <= '0;
    end else if (ctl_i.cfg_we && cfg_ok) begin
      capacity_q <= cfg_data_i;
      used_q     <= '0;
      in_use_q   <= '0;
      peak_q     <= '0;
      alloc_q    <= '0;
      fail_q     <= '0;
      rel_q      <= '0;
    end else if (ctl_i.exec) begin
      used_q     <= used_d;
      in_use_q   <= in_use_d;
      peak_q     <= peak_d;
      alloc_q    <= alloc_d;
      fail_q     <= fail_d;
      rel_q      <= rel_d;
    end
  end

  // Result beat strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= ctl_i.exec;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      res_o <= res_d;
    end
  end

endmodule

// ===== src/rbp_checker.sv =====
module rbp_checker
  import rbp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o,
  input logic cfg_ready_o
);

  // An accepted request yields its result beat once its execute state has passed
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("accepted request gave no result beat");

  // Results never come back to back
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Config is refused while a request is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o)
    else $error("config ready while busy");

  // Peak never falls below current use
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.blocks_in_use <= res_o.peak_in_use)
    else $error("peak below blocks in use");

  // A stored signal is shown only for a referenced block
  a_sig_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.event_signal != '0) |-> res_o.ref_count != '0)
    else $error("signal reported for a free block");

endmodule

bind refcounted_block_pool_top rbp_checker u_checker (.*);
